/* rtl/pcsm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// P-code machine package
// Shared opcodes, operator codes, error codes and request/result types.
// ----------------------------------------------------------------------------
package pcsm_pkg;

	localparam int DW = 32;

	typedef enum logic [3:0] {
		OPC_INT = 4'd0,
		OPC_LIT = 4'd1,
		OPC_LOD = 4'd2,
		OPC_STO = 4'd3,
		OPC_CAL = 4'd4,
		OPC_JMP = 4'd5,
		OPC_JPC = 4'd6,
		OPC_OPR = 4'd7,
		OPC_RET = 4'd8
	} opc_t;

	localparam logic [3:0] ALU_NEG   = 4'd0;
	localparam logic [3:0] ALU_ADD   = 4'd1;
	localparam logic [3:0] ALU_SUB   = 4'd2;
	localparam logic [3:0] ALU_MUL   = 4'd3;
	localparam logic [3:0] ALU_DIV   = 4'd4;
	localparam logic [3:0] ALU_MOD   = 4'd5;
	localparam logic [3:0] ALU_EQL   = 4'd6;
	localparam logic [3:0] ALU_NEQ   = 4'd7;
	localparam logic [3:0] ALU_LSS   = 4'd8;
	localparam logic [3:0] ALU_GEQ   = 4'd9;
	localparam logic [3:0] ALU_GTR   = 4'd10;
	localparam logic [3:0] ALU_LEQ   = 4'd11;
	localparam logic [3:0] ALU_WRT   = 4'd12;
	localparam logic [3:0] ALU_WRTLN = 4'd13;

	localparam logic [1:0] WK_NONE  = 2'd0;
	localparam logic [1:0] WK_WRT   = 2'd1;
	localparam logic [1:0] WK_WRTLN = 2'd2;

	typedef enum logic [3:0] {
		E_NONE    = 4'd0,
		E_UNDER   = 4'd1,
		E_OVER    = 4'd2,
		E_JUMP    = 4'd3,
		E_DIVZ    = 4'd4,
		E_MODZ    = 4'd5,
		E_BADOP   = 4'd6,
		E_LINK    = 4'd7,
		E_PC      = 4'd8,
		E_STOPPED = 4'd9
	} err_t;

	typedef enum logic [3:0] {
		K_INT, K_LIT, K_LOD, K_STO, K_CAL, K_JMP,
		K_JPC, K_NEG, K_WRT, K_BIN, K_RET, K_BAD
	} kind_t;

	typedef struct packed {
		logic [3:0]        opcode;
		logic [7:0]        static_level;
		logic signed [31:0] operand;
		logic              has_literal;
		logic signed [31:0] literal_value;
	} req_t;

	typedef struct packed {
		logic [15:0]        next_pc;
		logic               halted;
		logic [1:0]         write_kind;
		logic signed [31:0] write_value;
		logic [3:0]         error_code;
	} res_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         lvl;
		logic signed [31:0] opd;
		logic [31:0]        val;
		logic [3:0]         aop;
	} cmd_t;

endpackage
`default_nettype wire

/* rtl/pcsm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// P-code machine front end
// Accepts requests, classifies them and queues them for the executor.
// ----------------------------------------------------------------------------
module pcsm_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire pcsm_pkg::req_t  cmd,
	input  wire logic            hold,
	output logic                 q_valid,
	output pcsm_pkg::cmd_t       q_item,
	input  wire logic            q_pop
);

	pcsm_pkg::cmd_t dec;
	pcsm_pkg::cmd_t q_mem_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	always_comb begin
		dec.lvl = cmd.static_level;
		dec.opd = cmd.operand;
		dec.val = cmd.has_literal ? cmd.literal_value : cmd.operand;
		dec.aop = cmd.operand[3:0];
		unique case (cmd.opcode)
			pcsm_pkg::OPC_INT: dec.kind = pcsm_pkg::K_INT;
			pcsm_pkg::OPC_LIT: dec.kind = pcsm_pkg::K_LIT;
			pcsm_pkg::OPC_LOD: dec.kind = pcsm_pkg::K_LOD;
			pcsm_pkg::OPC_STO: dec.kind = pcsm_pkg::K_STO;
			pcsm_pkg::OPC_CAL: dec.kind = pcsm_pkg::K_CAL;
			pcsm_pkg::OPC_JMP: dec.kind = pcsm_pkg::K_JMP;
			pcsm_pkg::OPC_JPC: dec.kind = pcsm_pkg::K_JPC;
			pcsm_pkg::OPC_RET: dec.kind = pcsm_pkg::K_RET;
			pcsm_pkg::OPC_OPR: begin
				if (cmd.operand < 0 || cmd.operand > 32'sd13) begin
					dec.kind = pcsm_pkg::K_BAD;
				end else begin
					case (cmd.operand[3:0]) inside
						pcsm_pkg::ALU_NEG: dec.kind = pcsm_pkg::K_NEG;
						pcsm_pkg::ALU_WRT, pcsm_pkg::ALU_WRTLN: dec.kind = pcsm_pkg::K_WRT;
						default: dec.kind = pcsm_pkg::K_BIN;
					endcase
				end
			end
			default: dec.kind = pcsm_pkg::K_BAD;
		endcase
	end

	assign cmd_stall = hold || (cnt_q == 2'd2);
	assign push      = cmd_valid && !cmd_stall;
	assign pop       = q_pop && (cnt_q != 2'd0);
	assign q_valid   = (cnt_q != 2'd0);
	assign q_item    = q_mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wp_q] <= dec;
	end

endmodule
`default_nettype wire

/* rtl/pcsm_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// P-code machine divider
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module pcsm_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient,
	output logic [31:0]      remainder
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic        qneg_q;
	logic        rneg_q;
	logic [32:0] sh;
	logic [32:0] diff;
	logic        ge;

	assign sh   = {rem_q, quo_q[31]};
	assign diff = sh - {1'b0, dvs_q};
	assign ge   = !diff[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
			quo_q  <= 32'd0;
			rem_q  <= 32'd0;
			dvs_q  <= 32'd0;
			qneg_q <= 1'b0;
			rneg_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
				quo_q  <= dividend[31] ? (32'd0 - dividend) : dividend;
				dvs_q  <= divisor[31] ? (32'd0 - divisor) : divisor;
				rem_q  <= 32'd0;
				qneg_q <= dividend[31] ^ divisor[31];
				rneg_q <= dividend[31];
			end else if (busy_q) begin
				rem_q <= ge ? diff[31:0] : sh[31:0];
				quo_q <= {quo_q[30:0], ge};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = qneg_q ? (32'd0 - quo_q) : quo_q;
	assign remainder = rneg_q ? (32'd0 - rem_q) : rem_q;

endmodule
`default_nettype wire

/* rtl/pcsm_exec.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// P-code machine executor
// Runs queued instructions against the data stack and drives the result.
// ----------------------------------------------------------------------------
module pcsm_exec #(
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_wr_en,
	input  wire logic [16:0]    cfg_wr_data,
	input  wire logic           q_valid,
	input  wire pcsm_pkg::cmd_t q_item,
	output logic                q_pop,
	output logic                clearing,
	output logic                res_valid,
	input  wire logic           res_stall,
	output pcsm_pkg::res_t      res
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int TW = AW + 1;
	localparam int XW = 34;
	localparam logic signed [XW-1:0] DEPTH_X = XW'(STACK_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(STACK_DEPTH - 1);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DISP, S_WALK, S_WALKD, S_LODA, S_LODV, S_STOV,
		S_STOA, S_CAL1, S_CAL2, S_CAL3, S_JPCV, S_NEGV, S_WRTV, S_POPA,
		S_ALU, S_DIVW, S_RET1, S_RET2, S_FIN
	} state_t;

	state_t                state_q;
	state_t                after_q;
	logic [AW-1:0]         clr_q;
	pcsm_pkg::cmd_t        cmd_q;
	logic [7:0]            lvl_q;
	logic signed [TW-1:0]  top_q;
	logic signed [31:0]    fb_q;
	logic signed [31:0]    pc_q;
	logic signed [31:0]    cur_q;
	logic [31:0]           b_q;
	logic [31:0]           v_q;
	logic                  stopped_q;
	logic [16:0]           plen_q;
	pcsm_pkg::err_t        err_q;
	logic [1:0]            wk_q;
	logic [31:0]           wv_q;
	logic                  res_valid_q;
	pcsm_pkg::res_t        res_q;

	logic [31:0]           mem_q [STACK_DEPTH];
	logic [31:0]           rd_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	logic [31:0]           mem_wd;
	logic [AW-1:0]         mem_ra;

	logic signed [XW-1:0]  top_x, fb_x, cur_x, pc_x, opd_x, plen_x;
	logic signed [XW-1:0]  top_p1, top_p3, fb_p1, fb_p2, top_opd, cur_opd;
	logic                  jump_bad;
	logic                  pc_bad;
	logic [31:0]           alu_r;
	logic                  div_start;
	logic                  div_done;
	logic [31:0]           div_q;
	logic [31:0]           div_r;
	logic [31:0]           div_res;

	function automatic pcsm_pkg::err_t chk(input logic signed [XW-1:0] a);
		pcsm_pkg::err_t e;
		if (a < 0) e = pcsm_pkg::E_UNDER;
		else if (a >= DEPTH_X) e = pcsm_pkg::E_OVER;
		else e = pcsm_pkg::E_NONE;
		return e;
	endfunction

	assign top_x   = XW'(top_q);
	assign fb_x    = XW'(fb_q);
	assign cur_x   = XW'(cur_q);
	assign pc_x    = XW'(pc_q);
	assign opd_x   = XW'(cmd_q.opd);
	assign plen_x  = $signed(XW'(plen_q));
	assign top_p1  = top_x + 34'sd1;
	assign top_p3  = top_x + 34'sd3;
	assign fb_p1   = fb_x + 34'sd1;
	assign fb_p2   = fb_x + 34'sd2;
	assign top_opd = top_x + opd_x;
	assign cur_opd = cur_x + opd_x;
	assign jump_bad = (opd_x < 0) || (opd_x >= plen_x);
	assign pc_bad   = (pc_x < 0) || (pc_x >= plen_x);

	always_comb begin
		case (cmd_q.aop)
			pcsm_pkg::ALU_ADD: alu_r = rd_q + b_q;
			pcsm_pkg::ALU_SUB: alu_r = rd_q - b_q;
			pcsm_pkg::ALU_MUL: alu_r = rd_q * b_q;
			pcsm_pkg::ALU_EQL: alu_r = 32'(rd_q == b_q);
			pcsm_pkg::ALU_NEQ: alu_r = 32'(rd_q != b_q);
			pcsm_pkg::ALU_LSS: alu_r = 32'($signed(rd_q) < $signed(b_q));
			pcsm_pkg::ALU_GEQ: alu_r = 32'($signed(rd_q) >= $signed(b_q));
			pcsm_pkg::ALU_GTR: alu_r = 32'($signed(rd_q) > $signed(b_q));
			pcsm_pkg::ALU_LEQ: alu_r = 32'($signed(rd_q) <= $signed(b_q));
			default:           alu_r = 32'd0;
		endcase
	end

	assign div_start = (state_q == S_ALU) && (b_q != 32'd0) &&
		(cmd_q.aop == pcsm_pkg::ALU_DIV || cmd_q.aop == pcsm_pkg::ALU_MOD);
	assign div_res = (cmd_q.aop == pcsm_pkg::ALU_DIV) ? div_q : div_r;

	pcsm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rd_q),
		.divisor   (b_q),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = top_p1[AW-1:0];
		mem_wd = cmd_q.val;
		mem_ra = top_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = 32'd0;
			end
			S_DISP: begin
				if (cmd_q.kind == pcsm_pkg::K_LIT) begin
					mem_we = !stopped_q && !pc_bad && (chk(top_p1) == pcsm_pkg::E_NONE);
				end
				if (cmd_q.kind == pcsm_pkg::K_RET) mem_ra = fb_p2[AW-1:0];
			end
			S_WALK: mem_ra = cur_q[AW-1:0];
			S_LODA: mem_ra = cur_opd[AW-1:0];
			S_LODV: begin
				mem_we = (chk(top_p1) == pcsm_pkg::E_NONE);
				mem_wd = rd_q;
			end
			S_STOA: begin
				mem_we = (chk(cur_opd) == pcsm_pkg::E_NONE);
				mem_wa = cur_opd[AW-1:0];
				mem_wd = v_q;
			end
			S_CAL1: begin
				mem_we = 1'b1;
				mem_wd = cur_q;
			end
			S_CAL2: begin
				mem_we = 1'b1;
				mem_wa = AW'(top_x + 34'sd2);
				mem_wd = fb_q;
			end
			S_CAL3: begin
				mem_we = 1'b1;
				mem_wa = top_p3[AW-1:0];
				mem_wd = pc_q;
			end
			S_NEGV: begin
				mem_we = 1'b1;
				mem_wa = top_q[AW-1:0];
				mem_wd = 32'd0 - rd_q;
			end
			S_ALU: begin
				mem_we = (cmd_q.aop != pcsm_pkg::ALU_DIV) && (cmd_q.aop != pcsm_pkg::ALU_MOD) &&
					(chk(top_p1) == pcsm_pkg::E_NONE);
				mem_wd = alu_r;
			end
			S_DIVW: begin
				mem_we = div_done && (chk(top_p1) == pcsm_pkg::E_NONE);
				mem_wd = div_res;
			end
			S_RET1: mem_ra = fb_p1[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		rd_q <= mem_q[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			after_q     <= S_FIN;
			clr_q       <= '0;
			cmd_q       <= '0;
			lvl_q       <= 8'd0;
			top_q       <= -TW'(1);
			fb_q        <= 32'sd0;
			pc_q        <= 32'sd0;
			cur_q       <= 32'sd0;
			b_q         <= 32'd0;
			v_q         <= 32'd0;
			stopped_q   <= 1'b0;
			plen_q      <= 17'd1;
			err_q       <= pcsm_pkg::E_NONE;
			wk_q        <= pcsm_pkg::WK_NONE;
			wv_q        <= 32'd0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_wr_en) plen_q <= cfg_wr_data;
			if (res_valid_q && !res_stall) res_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						cmd_q   <= q_item;
						err_q   <= pcsm_pkg::E_NONE;
						wk_q    <= pcsm_pkg::WK_NONE;
						wv_q    <= 32'd0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_FIN;
					if (stopped_q) begin
						err_q <= pcsm_pkg::E_STOPPED;
					end else if (pc_bad) begin
						err_q <= pcsm_pkg::E_PC;
					end else begin
						pc_q <= pc_q + 32'sd1;
						case (cmd_q.kind) inside
							pcsm_pkg::K_INT: begin
								if (chk(top_opd) != pcsm_pkg::E_NONE) err_q <= chk(top_opd);
								else top_q <= TW'(top_opd);
							end
							pcsm_pkg::K_LIT: begin
								if (chk(top_p1) != pcsm_pkg::E_NONE) err_q <= chk(top_p1);
								else top_q <= TW'(top_p1);
							end
							pcsm_pkg::K_LOD: begin
								cur_q   <= fb_q;
								lvl_q   <= cmd_q.lvl;
								after_q <= S_LODA;
								state_q <= S_WALK;
							end
							pcsm_pkg::K_STO, pcsm_pkg::K_JPC, pcsm_pkg::K_WRT,
							pcsm_pkg::K_BIN: begin
								if (chk(top_x) != pcsm_pkg::E_NONE) begin
									err_q <= chk(top_x);
								end else begin
									top_q <= top_q - TW'(1);
									if (cmd_q.kind == pcsm_pkg::K_STO) state_q <= S_STOV;
									else if (cmd_q.kind == pcsm_pkg::K_JPC) state_q <= S_JPCV;
									else if (cmd_q.kind == pcsm_pkg::K_WRT) state_q <= S_WRTV;
									else state_q <= S_POPA;
								end
							end
							pcsm_pkg::K_NEG: begin
								if (chk(top_x) != pcsm_pkg::E_NONE) err_q <= chk(top_x);
								else state_q <= S_NEGV;
							end
							pcsm_pkg::K_CAL: begin
								if (jump_bad) begin
									err_q <= pcsm_pkg::E_JUMP;
								end else if (chk(top_p1) != pcsm_pkg::E_NONE) begin
									err_q <= chk(top_p1);
								end else if (chk(top_p3) != pcsm_pkg::E_NONE) begin
									err_q <= chk(top_p3);
								end else begin
									cur_q   <= fb_q;
									lvl_q   <= cmd_q.lvl;
									after_q <= S_CAL1;
									state_q <= S_WALK;
								end
							end
							pcsm_pkg::K_JMP: begin
								if (jump_bad) err_q <= pcsm_pkg::E_JUMP;
								else pc_q <= cmd_q.opd;
							end
							pcsm_pkg::K_RET: begin
								if (chk(fb_p1) != pcsm_pkg::E_NONE) err_q <= chk(fb_p1);
								else if (chk(fb_p2) != pcsm_pkg::E_NONE) err_q <= chk(fb_p2);
								else state_q <= S_RET1;
							end
							default: err_q <= pcsm_pkg::E_BADOP;
						endcase
					end
				end
				S_WALK: begin
					if (lvl_q == 8'd0) begin
						state_q <= after_q;
					end else if (cur_x < 0 || cur_x >= DEPTH_X) begin
						err_q   <= pcsm_pkg::E_LINK;
						state_q <= S_FIN;
					end else begin
						lvl_q   <= lvl_q - 8'd1;
						state_q <= S_WALKD;
					end
				end
				S_WALKD: begin
					cur_q   <= $signed(rd_q);
					state_q <= S_WALK;
				end
				S_LODA: begin
					if (chk(cur_opd) != pcsm_pkg::E_NONE) begin
						err_q   <= chk(cur_opd);
						state_q <= S_FIN;
					end else begin
						state_q <= S_LODV;
					end
				end
				S_LODV: begin
					if (chk(top_p1) != pcsm_pkg::E_NONE) err_q <= chk(top_p1);
					else top_q <= TW'(top_p1);
					state_q <= S_FIN;
				end
				S_STOV: begin
					v_q     <= rd_q;
					cur_q   <= fb_q;
					lvl_q   <= cmd_q.lvl;
					after_q <= S_STOA;
					state_q <= S_WALK;
				end
				S_STOA: begin
					if (chk(cur_opd) != pcsm_pkg::E_NONE) err_q <= chk(cur_opd);
					state_q <= S_FIN;
				end
				S_CAL1: state_q <= S_CAL2;
				S_CAL2: state_q <= S_CAL3;
				S_CAL3: begin
					fb_q    <= 32'(top_p1);
					pc_q    <= cmd_q.opd;
					state_q <= S_FIN;
				end
				S_JPCV: begin
					if (rd_q == 32'd0) begin
						if (jump_bad) err_q <= pcsm_pkg::E_JUMP;
						else pc_q <= cmd_q.opd;
					end
					state_q <= S_FIN;
				end
				S_NEGV: state_q <= S_FIN;
				S_WRTV: begin
					wk_q    <= (cmd_q.aop == pcsm_pkg::ALU_WRT) ? pcsm_pkg::WK_WRT :
						pcsm_pkg::WK_WRTLN;
					wv_q    <= rd_q;
					state_q <= S_FIN;
				end
				S_POPA: begin
					b_q <= rd_q;
					if (chk(top_x) != pcsm_pkg::E_NONE) begin
						err_q   <= chk(top_x);
						state_q <= S_FIN;
					end else begin
						top_q   <= top_q - TW'(1);
						state_q <= S_ALU;
					end
				end
				S_ALU: begin
					case (cmd_q.aop) inside
						pcsm_pkg::ALU_DIV, pcsm_pkg::ALU_MOD: begin
							if (b_q == 32'd0) begin
								err_q   <= (cmd_q.aop == pcsm_pkg::ALU_DIV) ? pcsm_pkg::E_DIVZ :
									pcsm_pkg::E_MODZ;
								state_q <= S_FIN;
							end else begin
								state_q <= S_DIVW;
							end
						end
						default: begin
							if (chk(top_p1) != pcsm_pkg::E_NONE) err_q <= chk(top_p1);
							else top_q <= TW'(top_p1);
							state_q <= S_FIN;
						end
					endcase
				end
				S_DIVW: begin
					if (div_done) begin
						if (chk(top_p1) != pcsm_pkg::E_NONE) err_q <= chk(top_p1);
						else top_q <= TW'(top_p1);
						state_q <= S_FIN;
					end
				end
				S_RET1: begin
					pc_q    <= $signed(rd_q);
					state_q <= S_RET2;
				end
				S_RET2: begin
					fb_q  <= $signed(rd_q);
					top_q <= TW'(fb_x - 34'sd1);
					if (pc_q == 32'sd0) stopped_q <= 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q       <= 1'b1;
						res_q.next_pc     <= pc_q[15:0];
						res_q.halted      <= stopped_q || (err_q != pcsm_pkg::E_NONE);
						res_q.write_kind  <= (err_q != pcsm_pkg::E_NONE) ? pcsm_pkg::WK_NONE : wk_q;
						res_q.write_value <= (err_q != pcsm_pkg::E_NONE) ? 32'sd0 : $signed(wv_q);
						res_q.error_code  <= err_q;
						if (err_q != pcsm_pkg::E_NONE) stopped_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign q_pop     = (state_q == S_IDLE);
	assign clearing  = (state_q == S_CLEAR);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

/* rtl/pcode_stack_machine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// P-code stack machine
// Executes one PL/0-style p-code instruction per request.
// ----------------------------------------------------------------------------
// LOD, STO and CAL take longer for each static link that they walk,
// and DIV and MOD by a nonzero divisor also wait for the serial divider.
// The machine runs one instruction at a time; the stack memory's read and write
// ports and the serial divider set the pace; a two-entry queue takes new requests.
// Reset: after arst_n releases, every stack word is cleared to zero before the
// first request is taken.
module pcode_stack_machine #(
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_wr_en,
	input  wire logic [16:0]    cfg_wr_data,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire pcsm_pkg::req_t cmd,
	output logic                res_valid,
	input  wire logic           res_stall,
	output pcsm_pkg::res_t      res
);

	logic           q_valid;
	pcsm_pkg::cmd_t q_item;
	logic           q_pop;
	logic           clearing;

	pcsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.hold      (clearing),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	pcsm_exec #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.clearing    (clearing),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res)
	);

endmodule
`default_nettype wire

/* rtl/pcsm_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// P-code machine checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pcsm_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           res_valid,
	input wire logic           res_stall,
	input wire pcsm_pkg::res_t res
);

	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.error_code != pcsm_pkg::E_NONE |-> res.halted)
		else $error("Result with an error does not report halted.");

	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.write_kind != pcsm_pkg::WK_NONE |->
		res.error_code == pcsm_pkg::E_NONE && !res.halted)
		else $error("Write result carries an error or halt.");

	a_no_write_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.write_kind == pcsm_pkg::WK_NONE |-> res.write_value == 32'sd0)
		else $error("Write value is nonzero without a write.");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("Stalled result changed.");

endmodule

bind pcode_stack_machine pcsm_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
`default_nettype wire

/* tb/sv/tb_pcode_stack_machine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P-code stack machine testbench
// Sends p-code requests through the valid/stall port. A predictor in the
// bench keeps its own stack, pointers and program length and checks every
// result. Instructions are drawn so that the machine keeps running until
// the last phase, which ends it on purpose. Program length is rewritten
// between phases while the machine is idle.
// ----------------------------------------------------------------------------
module tb_pcode_stack_machine;

	localparam int DEPTH = 1024;
	localparam int SETTLE = 700;
	localparam longint LIMIT = 6000000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [16:0] cfg_wr_data;
	logic cmd_valid;
	logic cmd_stall;
	pcsm_pkg::req_t cmd;
	logic res_valid;
	logic res_stall;
	pcsm_pkg::res_t res;

	pcode_stack_machine #(.STACK_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	typedef struct {
		pcsm_pkg::req_t r;
		bit typed;
		pcsm_pkg::res_t want;
	} row_t;

	logic [31:0] stk [DEPTH];
	logic [31:0] sv_stk [DEPTH];
	longint top, fbase, pcnt, plen;
	longint sv_top, sv_fbase, sv_pcnt;
	bit halt, sv_halt;

	pcsm_pkg::res_t pending_results[$];
	row_t dir_rows[$];
	int send_idle, recv_idle;
	int mismatches, checked, issued;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("pcode_stack_machine verification failed");
			$finish;
		end
	end

	function automatic longint sx(logic [31:0] w);
		return longint'($signed(w));
	endfunction

	function automatic pcsm_pkg::err_t addr_ok(longint a);
		if (a < 0) return pcsm_pkg::E_UNDER;
		if (a >= DEPTH) return pcsm_pkg::E_OVER;
		return pcsm_pkg::E_NONE;
	endfunction

	function automatic pcsm_pkg::err_t push_word(longint v);
		pcsm_pkg::err_t e;
		e = addr_ok(top + 1);
		if (e != pcsm_pkg::E_NONE) return e;
		top = top + 1;
		stk[top] = v[31:0];
		return pcsm_pkg::E_NONE;
	endfunction

	function automatic pcsm_pkg::err_t pop_word(output longint v);
		pcsm_pkg::err_t e;
		v = 0;
		e = addr_ok(top);
		if (e != pcsm_pkg::E_NONE) return e;
		v = sx(stk[top]);
		top = top - 1;
		return pcsm_pkg::E_NONE;
	endfunction

	function automatic pcsm_pkg::err_t follow_links(int unsigned lvl, output longint base);
		longint cur;
		cur = fbase;
		base = 0;
		while (lvl > 0) begin
			if (cur < 0 || cur >= DEPTH) return pcsm_pkg::E_LINK;
			cur = sx(stk[cur]);
			lvl--;
		end
		base = cur;
		return pcsm_pkg::E_NONE;
	endfunction

	function automatic pcsm_pkg::err_t target_ok(longint t);
		return (t < 0 || t >= plen) ? pcsm_pkg::E_JUMP : pcsm_pkg::E_NONE;
	endfunction

	function automatic pcsm_pkg::err_t run_alu(longint code, output logic [1:0] wk,
			output logic [31:0] wv);
		longint a, b, q;
		logic [31:0] t;
		pcsm_pkg::err_t e;
		wk = pcsm_pkg::WK_NONE;
		wv = '0;
		if (code < 0 || code > 13) return pcsm_pkg::E_BADOP;
		if (code == pcsm_pkg::ALU_NEG) begin
			e = addr_ok(top);
			if (e != pcsm_pkg::E_NONE) return e;
			stk[top] = 32'd0 - stk[top];
			return pcsm_pkg::E_NONE;
		end
		if (code == pcsm_pkg::ALU_WRT || code == pcsm_pkg::ALU_WRTLN) begin
			e = pop_word(a);
			if (e != pcsm_pkg::E_NONE) return e;
			wk = (code == pcsm_pkg::ALU_WRT) ? pcsm_pkg::WK_WRT : pcsm_pkg::WK_WRTLN;
			wv = a[31:0];
			return pcsm_pkg::E_NONE;
		end
		e = pop_word(b);
		if (e != pcsm_pkg::E_NONE) return e;
		e = pop_word(a);
		if (e != pcsm_pkg::E_NONE) return e;
		case (code[3:0])
			pcsm_pkg::ALU_ADD: t = a[31:0] + b[31:0];
			pcsm_pkg::ALU_SUB: t = a[31:0] - b[31:0];
			pcsm_pkg::ALU_MUL: t = a[31:0] * b[31:0];
			pcsm_pkg::ALU_DIV: begin
				if (b == 0) return pcsm_pkg::E_DIVZ;
				q = a / b;
				t = q[31:0];
			end
			pcsm_pkg::ALU_MOD: begin
				if (b == 0) return pcsm_pkg::E_MODZ;
				q = a % b;
				t = q[31:0];
			end
			pcsm_pkg::ALU_EQL: t = {31'd0, a == b};
			pcsm_pkg::ALU_NEQ: t = {31'd0, a != b};
			pcsm_pkg::ALU_LSS: t = {31'd0, a < b};
			pcsm_pkg::ALU_GEQ: t = {31'd0, a >= b};
			pcsm_pkg::ALU_GTR: t = {31'd0, a > b};
			default: t = {31'd0, a <= b};
		endcase
		return push_word(sx(t));
	endfunction

	function automatic pcsm_pkg::err_t run_instr(pcsm_pkg::req_t r, output logic [1:0] wk,
			output logic [31:0] wv);
		longint opd, v, b, addr, ret_pc, ret_base;
		pcsm_pkg::err_t e;
		opd = sx(r.operand);
		wk = pcsm_pkg::WK_NONE;
		wv = '0;
		case (r.opcode)
			pcsm_pkg::OPC_INT: begin
				addr = top + opd;
				e = addr_ok(addr);
				if (e != pcsm_pkg::E_NONE) return e;
				top = addr;
				return pcsm_pkg::E_NONE;
			end
			pcsm_pkg::OPC_LIT: return push_word(r.has_literal ? sx(r.literal_value) : opd);
			pcsm_pkg::OPC_LOD: begin
				e = follow_links(r.static_level, b);
				if (e != pcsm_pkg::E_NONE) return e;
				addr = b + opd;
				e = addr_ok(addr);
				if (e != pcsm_pkg::E_NONE) return e;
				return push_word(sx(stk[addr]));
			end
			pcsm_pkg::OPC_STO: begin
				e = pop_word(v);
				if (e != pcsm_pkg::E_NONE) return e;
				e = follow_links(r.static_level, b);
				if (e != pcsm_pkg::E_NONE) return e;
				addr = b + opd;
				e = addr_ok(addr);
				if (e != pcsm_pkg::E_NONE) return e;
				stk[addr] = v[31:0];
				return pcsm_pkg::E_NONE;
			end
			pcsm_pkg::OPC_CAL: begin
				e = target_ok(opd);
				if (e != pcsm_pkg::E_NONE) return e;
				e = addr_ok(top + 1);
				if (e != pcsm_pkg::E_NONE) return e;
				e = addr_ok(top + 3);
				if (e != pcsm_pkg::E_NONE) return e;
				e = follow_links(r.static_level, b);
				if (e != pcsm_pkg::E_NONE) return e;
				stk[top + 1] = b[31:0];
				stk[top + 2] = fbase[31:0];
				stk[top + 3] = pcnt[31:0];
				fbase = top + 1;
				pcnt = opd;
				return pcsm_pkg::E_NONE;
			end
			pcsm_pkg::OPC_JMP: begin
				e = target_ok(opd);
				if (e != pcsm_pkg::E_NONE) return e;
				pcnt = opd;
				return pcsm_pkg::E_NONE;
			end
			pcsm_pkg::OPC_JPC: begin
				e = pop_word(v);
				if (e != pcsm_pkg::E_NONE) return e;
				if (v == 0) begin
					e = target_ok(opd);
					if (e != pcsm_pkg::E_NONE) return e;
					pcnt = opd;
				end
				return pcsm_pkg::E_NONE;
			end
			pcsm_pkg::OPC_OPR: return run_alu(opd, wk, wv);
			pcsm_pkg::OPC_RET: begin
				e = addr_ok(fbase + 1);
				if (e != pcsm_pkg::E_NONE) return e;
				e = addr_ok(fbase + 2);
				if (e != pcsm_pkg::E_NONE) return e;
				top = fbase - 1;
				ret_pc = sx(stk[fbase + 2]);
				ret_base = sx(stk[fbase + 1]);
				pcnt = ret_pc;
				fbase = ret_base;
				if (pcnt == 0) halt = 1'b1;
				return pcsm_pkg::E_NONE;
			end
			default: return pcsm_pkg::E_BADOP;
		endcase
	endfunction

	function automatic pcsm_pkg::res_t execute(pcsm_pkg::req_t r);
		pcsm_pkg::res_t o;
		pcsm_pkg::err_t e;
		logic [1:0] wk;
		logic [31:0] wv;
		wk = pcsm_pkg::WK_NONE;
		wv = '0;
		if (halt) begin
			e = pcsm_pkg::E_STOPPED;
		end else if (pcnt < 0 || pcnt >= plen) begin
			e = pcsm_pkg::E_PC;
		end else begin
			pcnt = pcnt + 1;
			e = run_instr(r, wk, wv);
		end
		if (e != pcsm_pkg::E_NONE) begin
			halt = 1'b1;
			wk = pcsm_pkg::WK_NONE;
			wv = '0;
		end
		o.next_pc = pcnt[15:0];
		o.halted = halt;
		o.write_kind = wk;
		o.write_value = wv;
		o.error_code = e;
		return o;
	endfunction

	function automatic void save_state();
		sv_stk = stk;
		sv_top = top;
		sv_fbase = fbase;
		sv_pcnt = pcnt;
		sv_halt = halt;
	endfunction

	function automatic void restore_state();
		stk = sv_stk;
		top = sv_top;
		fbase = sv_fbase;
		pcnt = sv_pcnt;
		halt = sv_halt;
	endfunction

	function automatic pcsm_pkg::req_t mk(pcsm_pkg::opc_t op, int lvl, logic [31:0] opd,
			bit hl, logic [31:0] lit);
		pcsm_pkg::req_t r;
		r.opcode = op;
		r.static_level = lvl[7:0];
		r.operand = opd;
		r.has_literal = hl;
		r.literal_value = lit;
		return r;
	endfunction

	function automatic logic [31:0] any_value();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($urandom_range(20)) - 32'd5;
			2: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'hffff_ffff;
					default: return 32'd0;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	function automatic pcsm_pkg::req_t random_instr(bit wild);
		pcsm_pkg::req_t r;
		int k;
		r.opcode = wild && $urandom_range(3) == 0 ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(8));
		k = $urandom_range(99);
		r.static_level = k < 70 ? 8'($urandom_range(2)) : k < 90 ? 8'($urandom_range(3, 8))
			: 8'($urandom());
		r.has_literal = 1'($urandom_range(1));
		r.literal_value = any_value();
		case (r.opcode)
			pcsm_pkg::OPC_INT: r.operand = 32'($urandom_range(7)) - 32'd3;
			pcsm_pkg::OPC_LIT: r.operand = any_value();
			pcsm_pkg::OPC_LOD, pcsm_pkg::OPC_STO: r.operand = 32'($urandom_range(11)) - 32'd2;
			pcsm_pkg::OPC_CAL, pcsm_pkg::OPC_JMP, pcsm_pkg::OPC_JPC: begin
				if ($urandom_range(19) == 0) r.operand = $urandom();
				else r.operand = 32'($urandom_range(plen > 64 ? 63 : int'(plen) - 1));
				if ($urandom_range(9) == 0) r.operand = 32'($urandom_range(int'(plen) - 1));
			end
			pcsm_pkg::OPC_OPR: r.operand = $urandom_range(29) == 0 ? $urandom()
				: 32'($urandom_range(13));
			default: r.operand = $urandom();
		endcase
		return r;
	endfunction

	task automatic send_request(pcsm_pkg::req_t r);
		if ($urandom_range(99) < send_idle) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		cmd <= r;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		issued++;
	endtask

	// Draws instructions until one keeps the machine alive, or ends it when
	// finishing is asked for.
	task automatic issue_random(bit finishing);
		pcsm_pkg::req_t r;
		pcsm_pkg::res_t o;
		bit found;
		found = 1'b0;
		for (int i = 0; i < 40 && !found; i++) begin
			r = random_instr(finishing);
			save_state();
			o = execute(r);
			if (finishing ? halt : (!halt && pcnt >= 0 && pcnt < plen)) found = 1'b1;
			else restore_state();
		end
		if (!found) begin
			r = finishing ? mk(pcsm_pkg::OPC_RET, 0, 32'd0, 1'b0, 32'd0)
				: mk(pcsm_pkg::OPC_JMP, 0, 32'($urandom_range(int'(plen) - 1)), 1'b0,
					$urandom());
			if (finishing) r.opcode = 4'hf;
			o = execute(r);
		end
		pending_results.push_back(o);
		send_request(r);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_length(int unsigned len);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= len[16:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		plen = len;
	endtask

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s at cycle %0d: got %0h, want %0h", field, cycles, got, want);
		mismatches++;
	endtask

	task automatic check_result(pcsm_pkg::res_t got);
		pcsm_pkg::res_t want;
		if (pending_results.size() == 0) begin
			report("unexpected result", 64'(got), 64'd0);
		end else begin
			want = pending_results.pop_front();
			checked++;
			if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
			if (got.halted !== want.halted) report("halted", got.halted, want.halted);
			if (got.write_kind !== want.write_kind)
				report("write_kind", got.write_kind, want.write_kind);
			if (got.write_value !== want.write_value)
				report("write_value", got.write_value, want.write_value);
			if (got.error_code !== want.error_code)
				report("error_code", got.error_code, want.error_code);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) check_result(res);
		res_stall <= ($urandom_range(99) < recv_idle);
	end

	initial begin
		row_t row;
		pcsm_pkg::res_t o;
		int unsigned lengths [6];
		int counts [6];
		lengths = '{65536, 1, 37, 65536, 300, 65536};
		counts = '{320, 60, 300, 340, 290, 330};
		mismatches = 0;
		checked = 0;
		issued = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		cmd_valid = 1'b0;
		cmd = '0;
		send_idle = 21;
		recv_idle = 73;
		for (int i = 0; i < DEPTH; i++) stk[i] = '0;
		top = -1;
		fbase = 0;
		pcnt = 0;
		plen = 1;
		halt = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// With the reset length of one, only jumps and calls to zero keep running.
		row.typed = 1'b1;
		row.r = mk(pcsm_pkg::OPC_JMP, 0, 32'd0, 1'b0, 32'hffff_ffff);
		row.want = {16'd0, 1'b0, pcsm_pkg::WK_NONE, 32'sd0, pcsm_pkg::E_NONE};
		dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_CAL, 0, 32'd0, 1'b1, 32'h8000_0000);
		dir_rows.push_back(row);
		foreach (dir_rows[i]) begin
			o = execute(dir_rows[i].r);
			pending_results.push_back(dir_rows[i].typed ? dir_rows[i].want : o);
			send_request(dir_rows[i].r);
		end
		wait_drained();
		write_length(65536);

		dir_rows.delete();
		row.typed = 1'b0;
		row.want = '0;
		row.r = mk(pcsm_pkg::OPC_INT, 0, 32'd3, 1'b0, 32'd0);            dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_LIT, 0, 32'h7fff_ffff, 1'b0, 32'd0);    dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_LIT, 0, 32'hffff_ffff, 1'b1, 32'h8000_0000);
		dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_OPR, 0, 32'(pcsm_pkg::ALU_ADD), 1'b0, 32'd0);
		dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_LIT, 0, 32'd0, 1'b1, 32'h8000_0000);    dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_LIT, 0, 32'hffff_ffff, 1'b0, 32'd0);    dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_OPR, 0, 32'(pcsm_pkg::ALU_DIV), 1'b0, 32'd0);
		dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_OPR, 0, 32'(pcsm_pkg::ALU_MUL), 1'b0, 32'd0);
		dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_LIT, 0, 32'hffff_ffff, 1'b0, 32'd0);    dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_OPR, 0, 32'(pcsm_pkg::ALU_MOD), 1'b0, 32'd0);
		dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_OPR, 0, 32'(pcsm_pkg::ALU_NEG), 1'b0, 32'd0);
		dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_LIT, 0, 32'd7, 1'b0, 32'd0);            dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_OPR, 0, 32'(pcsm_pkg::ALU_LSS), 1'b0, 32'd0);
		dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_LIT, 0, 32'd1, 1'b0, 32'd0);            dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_OPR, 0, 32'(pcsm_pkg::ALU_SUB), 1'b0, 32'd0);
		dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_JPC, 0, 32'd5, 1'b0, 32'd0);            dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_LIT, 0, 32'd9, 1'b0, 32'd0);            dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_STO, 1, 32'd0, 1'b0, 32'd0);            dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_LOD, 0, 32'd0, 1'b0, 32'd0);            dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_OPR, 0, 32'(pcsm_pkg::ALU_WRTLN), 1'b0, 32'd0);
		dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_LIT, 0, 32'd4, 1'b0, 32'd0);            dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_OPR, 0, 32'(pcsm_pkg::ALU_WRT), 1'b0, 32'd0);
		dir_rows.push_back(row);
		row.r = mk(pcsm_pkg::OPC_RET, 0, 32'd0, 1'b0, 32'd0);            dir_rows.push_back(row);
		foreach (dir_rows[i]) begin
			o = execute(dir_rows[i].r);
			pending_results.push_back(o);
			send_request(dir_rows[i].r);
		end

		for (int ph = 0; ph < 6; ph++) begin
			send_idle = ph < 2 ? 21 : ph < 4 ? 73 : 0;
			recv_idle = ph < 2 ? 73 : ph < 4 ? 21 : 0;
			// Park the counter at zero so that any new length keeps it in range.
			o = execute(mk(pcsm_pkg::OPC_JMP, 0, 32'd0, 1'b0, 32'd0));
			pending_results.push_back(o);
			send_request(mk(pcsm_pkg::OPC_JMP, 0, 32'd0, 1'b0, 32'd0));
			wait_drained();
			write_length(lengths[ph]);
			for (int n = 0; n < counts[ph]; n++) issue_random(1'b0);
		end

		issue_random(1'b1);
		for (int n = 0; n < 4; n++) issue_random(1'b1);
		wait_drained();

		$display("%0d requests sent and %0d results checked over six program lengths,",
			issued, checked);
		$display("ending with a stopped machine; %0d mismatches seen.", mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("pcode_stack_machine verification clean");
		end else begin
			$display("pcode_stack_machine verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/pcsm_pkg.sv
rtl/pcsm_front.sv
rtl/pcsm_div.sv
rtl/pcsm_exec.sv
rtl/pcode_stack_machine.sv
rtl/pcsm_chk.sv
tb/sv/tb_pcode_stack_machine.sv
